// ===== design/pndg_pkg.sv =====
package pndg_pkg;

   // Request kinds carried on req_tuser.
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_GEN  = 1'b1
   } opcode_type;

   localparam int DIE_W      = 19;
   localparam int SUM_W      = 23;
   localparam int WORD_W     = 32;
   localparam int DIE_SHIFT  = 13;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 32;

   // Exponent bases: 127 minus the fixed-point scale of each range.
   localparam logic [7:0] EXP_BASE_HI = 8'd106;
   localparam logic [7:0] EXP_BASE_LO = 8'd105;

   // Trailing-zero count of a word, zero for a zero word.
   function automatic logic [4:0] trailing_zeros(input logic [WORD_W-1:0] w);
      logic [4:0] n;
      n = 5'd0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (w[i]) begin
            n = 5'(i);
         end
      end
      return n;
   endfunction

   // Position of the highest set bit of a 24-bit magnitude.
   function automatic logic [4:0] top_bit(input logic [23:0] a);
      logic [4:0] p;
      p = 5'd0;
      for (int i = 0; i < 24; i++) begin
         if (a[i]) begin
            p = 5'(i);
         end
      end
      return p;
   endfunction

endpackage

// ===== design/pink_noise_dice_generator.sv =====
// Voss-McCartney pink noise source with NUM_DICE dice of 19 bits held in a
// small synchronous RAM. A generate request (req_tuser high) replaces the die
// chosen by the trailing-zero count of its random word and returns one
// single-precision sample in roughly [-1, 1); a load request (req_tuser low)
// writes one die and returns nothing. One request is taken every clock cycle
// while the output is not stalled; a sample passes the stage 1, 2, 3 and
// output registers. The rate is set by the read-modify-write of the die
// memory, whose registered read is covered by forwarding from the previous
// write. Dice read as zero after reset until written: no clearing pass.
module pink_noise_dice_generator #(
   parameter int NUM_DICE = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: entry_index[3:0], entry_value[22:4], rand_word[54:23],
   // rand_extra[73:55], zero fill[79:74].
   input  logic [pndg_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Fields: opcode.
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: sample_bits[31:0].
   output logic [pndg_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import pndg_pkg::*;

   localparam int IDX_W = $clog2(NUM_DICE);

   // Request fields.
   logic [3:0]        req_index;
   logic [DIE_W-1:0]  req_value;
   logic [WORD_W-1:0] req_word;
   logic [DIE_W-1:0]  req_extra;
   opcode_type        req_op;

   assign req_index = req_tdata[3:0];
   assign req_value = req_tdata[22:4];
   assign req_word  = req_tdata[54:23];
   assign req_extra = req_tdata[73:55];
   assign req_op    = opcode_type'(req_tuser);

   // The whole pipeline moves when the output register can take a new sample.
   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   logic accept;
   assign accept = req_tvalid && advance;

   // Stage 0: choose the die and its new value, issue the memory read.
   logic [4:0]       s0_tz;
   logic [4:0]       s0_pick;
   logic [IDX_W-1:0] s0_addr;
   logic             s0_wr;
   logic [DIE_W-1:0] s0_value;

   always_comb begin
      s0_tz   = trailing_zeros(req_word);
      s0_pick = {1'b0, s0_tz[3:0]};
      if (s0_pick >= 5'(NUM_DICE)) begin
         s0_pick = 5'(NUM_DICE - 1);
      end
      if (req_op == OP_GEN) begin
         s0_addr  = IDX_W'(s0_pick);
         s0_wr    = 1'b1;
         s0_value = DIE_W'(req_word >> DIE_SHIFT);
      end else begin
         s0_addr  = IDX_W'(req_index);
         s0_wr    = ({1'b0, req_index} < 5'(NUM_DICE));
         s0_value = req_value;
      end
   end

   // Stage 1 registers.
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_gen_ff;
   logic             s1_wr_ff;
   logic [IDX_W-1:0] s1_addr_ff;
   logic [DIE_W-1:0] s1_value_ff;
   logic [DIE_W-1:0] s1_extra_ff;

   // Last write, for forwarding over the memory's read-old behaviour.
   logic             fwd_valid_ff, fwd_valid_in;
   logic [IDX_W-1:0] fwd_addr_ff;
   logic [DIE_W-1:0] fwd_data_ff;

   logic [NUM_DICE-1:0] written_ff, written_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;

   logic [DIE_W-1:0] ram_rd_data;
   logic             ram_wr_en;

   assign ram_wr_en = s1_valid_ff && s1_wr_ff && advance;

   pndg_ram #(
      .WIDTH (DIE_W),
      .DEPTH (NUM_DICE)
   ) u_dice (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_value_ff),
      .rd_en   (accept),
      .rd_addr (s0_addr),
      .rd_data (ram_rd_data)
   );

   // Stage 1: old die value, new running sum, sum plus the white value.
   logic [DIE_W-1:0] s1_old;
   logic [SUM_W-1:0] s1_sum;
   logic [23:0]      s1_total;

   always_comb begin
      if (fwd_valid_ff && fwd_addr_ff == s1_addr_ff) begin
         s1_old = fwd_data_ff;
      end else if (written_ff[s1_addr_ff]) begin
         s1_old = ram_rd_data;
      end else begin
         s1_old = '0;
      end
      s1_sum   = sum_ff + SUM_W'(s1_value_ff) - SUM_W'(s1_old);
      s1_total = {1'b0, s1_sum} + 24'(s1_extra_ff);
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      fwd_valid_in = fwd_valid_ff;
      written_in   = written_ff;
      sum_in       = sum_ff;
      if (advance) begin
         s1_valid_in  = req_tvalid;
         fwd_valid_in = s1_valid_ff && s1_wr_ff;
         if (s1_valid_ff && s1_wr_ff) begin
            written_in[s1_addr_ff] = 1'b1;
            sum_in                 = s1_sum;
         end
      end
   end

   // Stage 2: sample as a signed fixed-point magnitude.
   logic        s2_valid_ff, s2_valid_in;
   logic [23:0] s2_total_ff;
   logic        s2_hi;
   logic [23:0] s2_mag;
   logic        s2_neg;

   always_comb begin
      s2_hi = s2_total_ff[23];
      if (s2_hi) begin
         // Range [4, 8): value minus three is (2^21 + m) / 2^21.
         s2_mag = 24'h200000 + {1'b0, s2_total_ff[22:0]};
         s2_neg = 1'b0;
      end else begin
         // Range [2, 4): value minus three is (m - 2^22) / 2^22.
         s2_neg = !s2_total_ff[22];
         if (s2_neg) begin
            s2_mag = 24'h400000 - {1'b0, s2_total_ff[22:0]};
         end else begin
            s2_mag = {1'b0, s2_total_ff[22:0]} - 24'h400000;
         end
      end
   end

   // Stage 3: normalise and pack the single.
   logic        s3_valid_ff, s3_valid_in;
   logic        s3_hi_ff;
   logic        s3_neg_ff;
   logic [23:0] s3_mag_ff;
   logic [4:0]  s3_top;
   logic [23:0] s3_norm;
   logic [7:0]  s3_exp;
   logic [31:0] s3_bits;

   always_comb begin
      s3_top  = top_bit(s3_mag_ff);
      s3_norm = s3_mag_ff << (5'd23 - s3_top);
      s3_exp  = (s3_hi_ff ? EXP_BASE_HI : EXP_BASE_LO) + 8'(s3_top);
      if (s3_mag_ff == '0) begin
         s3_bits = '0;
      end else begin
         s3_bits = {s3_neg_ff, s3_exp, s3_norm[22:0]};
      end
   end

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff;

   always_comb begin
      s2_valid_in  = s2_valid_ff;
      s3_valid_in  = s3_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         s2_valid_in  = s1_valid_ff && s1_gen_ff;
         s3_valid_in  = s2_valid_ff;
         rsp_valid_in = s3_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
         written_ff   <= '0;
         sum_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         written_ff   <= written_in;
         sum_ff       <= sum_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_gen_ff   <= (req_op == OP_GEN);
         s1_wr_ff    <= s0_wr;
         s1_addr_ff  <= s0_addr;
         s1_value_ff <= s0_value;
         s1_extra_ff <= req_extra;
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= s1_value_ff;
         s2_total_ff <= s1_total;
         s3_hi_ff    <= s2_hi;
         s3_neg_ff   <= s2_neg;
         s3_mag_ff   <= s2_mag;
         rsp_data_ff <= s3_bits;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The running sum never exceeds the largest possible total of the dice.
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      24'(sum_ff) <= 24'(NUM_DICE) * 24'h7FFFF)
      else $error("running sum out of range");

   // A die write always targets an existing die.
   a_wr_addr: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> 5'(s1_addr_ff) < 5'(NUM_DICE))
      else $error("die write beyond the last die");

   // A sample in the last stage reaches the output register when it advances.
   a_out_follow: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && advance |=> rsp_tvalid)
      else $error("sample lost before the output register");

endmodule

// ===== design/pndg_ram.sv =====
module pndg_ram #(
   parameter int WIDTH = 19,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read in the same cycle as a write to that entry returns the old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
